// ===== rtl/swber_pkg.sv =====
// Shared types and constants for the sliding window bit error rate meter.
// No dependencies.
package swber_pkg;

  localparam int WINDOW      = 1024;
  localparam int POS_W       = $clog2(WINDOW);
  localparam int CNT_W       = 11;
  localparam int RATE_W      = 16;
  localparam int QUO_W       = RATE_W + 1;
  localparam int STEP_W      = $clog2(RATE_W);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam logic signed [7:0] BIT_LIMIT = 8'sd2;

  typedef struct packed {
    logic signed [7:0] received_symbol;
    logic signed [7:0] reference_symbol;
  } in_item_t;

  typedef struct packed {
    logic [RATE_W-1:0] error_rate;
    logic [CNT_W-1:0]  bits_in_window;
    logic [CNT_W-1:0]  errors_in_window;
  } out_item_t;

  typedef struct packed {
    logic err;
    logic vld;
  } mark_t;

  localparam mark_t MARK_RESET = '{err: 1'b0, vld: 1'b1};

endpackage

// ===== rtl/swber_front.sv =====
// Front end: accepts words, marks them as bit or erasure and error, and queues the marks.
// Depends on swber_pkg.
module swber_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  swber_pkg::in_item_t in_item,
  output logic                q_vld,
  output swber_pkg::mark_t    q_mark,
  input  logic                q_pop
);

  swber_pkg::mark_t                 q_r [swber_pkg::QUEUE_DEPTH];
  logic [swber_pkg::QPTR_W-1:0]     wr_r;
  logic [swber_pkg::QPTR_W-1:0]     rd_r;
  logic [swber_pkg::QCNT_W-1:0]     cnt_r;
  logic                             push_ok;
  logic                             pop_ok;
  swber_pkg::mark_t                 mark_nxt;

  assign in_full = (cnt_r == swber_pkg::QCNT_W'(swber_pkg::QUEUE_DEPTH));
  assign q_vld   = (cnt_r != '0);
  assign q_mark  = q_r[rd_r];
  assign push_ok = in_push && !in_full;
  assign pop_ok  = q_pop && q_vld;

  always_comb begin
    mark_nxt.vld = ($signed(in_item.received_symbol) < swber_pkg::BIT_LIMIT);
    mark_nxt.err = mark_nxt.vld && (in_item.received_symbol != in_item.reference_symbol);
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      q_r[wr_r] <= mark_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push_ok) begin
        wr_r <= (wr_r == swber_pkg::QPTR_W'(swber_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_r + 1'b1;
      end
      if (pop_ok) begin
        rd_r <= (rd_r == swber_pkg::QPTR_W'(swber_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_r + 1'b1;
      end
      if (push_ok && !pop_ok) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop_ok && !push_ok) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/swber_div.sv =====
// Serial divider: errors * 2^16 / bits, one quotient bit per cycle, saturated.
// Depends on swber_pkg.
module swber_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [swber_pkg::CNT_W-1:0]     num,
  input  logic [swber_pkg::CNT_W-1:0]     den,
  output logic                            done,
  output logic [swber_pkg::RATE_W-1:0]    rate
);

  logic                            busy_r;
  logic                            done_r;
  logic [swber_pkg::STEP_W-1:0]    step_r;
  logic [swber_pkg::CNT_W-1:0]     rem_r;
  logic [swber_pkg::QUO_W-1:0]     quo_r;
  logic [swber_pkg::CNT_W-1:0]     den_r;
  logic [swber_pkg::CNT_W:0]       trial;
  logic                            fits;

  assign trial = {rem_r, 1'b0};
  assign fits  = (trial >= {1'b0, den_r});
  assign done  = done_r;

  always_comb begin
    if (den_r == '0) begin
      rate = '0;
    end else if (quo_r[swber_pkg::QUO_W-1]) begin
      rate = '1;
    end else begin
      rate = quo_r[swber_pkg::RATE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      den_r <= den;
      if (num >= den) begin
        quo_r <= swber_pkg::QUO_W'(1);
        rem_r <= num - den;
      end else begin
        quo_r <= '0;
        rem_r <= num;
      end
    end else if (busy_r) begin
      if (fits) begin
        rem_r <= swber_pkg::CNT_W'(trial - {1'b0, den_r});
        quo_r <= {quo_r[swber_pkg::QUO_W-2:0], 1'b1};
      end else begin
        rem_r <= trial[swber_pkg::CNT_W-1:0];
        quo_r <= {quo_r[swber_pkg::QUO_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      step_r <= '0;
    end else if (busy_r) begin
      step_r <= step_r + 1'b1;
      if (step_r == swber_pkg::STEP_W'(swber_pkg::RATE_W - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

endmodule

// ===== rtl/swber_back.sv =====
// Back end: window mark memory, running bit and error counts, ratio, result register.
// Depends on swber_pkg and swber_div.
module swber_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_vld,
  input  swber_pkg::mark_t      q_mark,
  output logic                  q_pop,
  output logic                  out_empty,
  input  logic                  out_pop,
  output swber_pkg::out_item_t  out_item
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_UPD   = 2'd1;
  localparam logic [1:0] S_START = 2'd2;
  localparam logic [1:0] S_DIV   = 2'd3;

  logic [1:0]                       st_r;
  logic [1:0]                       st_nxt;
  swber_pkg::mark_t                 mem_r [swber_pkg::WINDOW];
  swber_pkg::mark_t                 rd_r;
  swber_pkg::mark_t                 mark_r;
  swber_pkg::mark_t                 old_mark;
  logic [swber_pkg::POS_W-1:0]      pos_r;
  logic                             wrap_r;
  logic [swber_pkg::CNT_W-1:0]      bit_cnt_r;
  logic [swber_pkg::CNT_W-1:0]      bit_cnt_nxt;
  logic [swber_pkg::CNT_W-1:0]      err_cnt_r;
  logic [swber_pkg::CNT_W-1:0]      err_cnt_nxt;
  logic                             out_vld_r;
  swber_pkg::out_item_t             out_r;
  logic                             out_free;
  logic                             load;
  logic                             div_start;
  logic                             div_done;
  logic [swber_pkg::RATE_W-1:0]     div_rate;

  swber_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (err_cnt_r),
    .den   (bit_cnt_r),
    .done  (div_done),
    .rate  (div_rate)
  );

  assign q_pop     = (st_r == S_IDLE) && q_vld;
  assign div_start = (st_r == S_START);
  assign out_free  = !out_vld_r || out_pop;
  assign load      = (st_r == S_DIV) && div_done && out_free;
  assign out_empty = !out_vld_r;
  assign out_item  = out_r;
  assign old_mark  = wrap_r ? rd_r : swber_pkg::MARK_RESET;

  always_comb begin
    bit_cnt_nxt = bit_cnt_r;
    err_cnt_nxt = err_cnt_r;
    if (old_mark.vld) begin
      if (bit_cnt_nxt != '0) begin
        bit_cnt_nxt = bit_cnt_nxt - 1'b1;
      end
      if (old_mark.err && (err_cnt_nxt != '0)) begin
        err_cnt_nxt = err_cnt_nxt - 1'b1;
      end
    end
    if (mark_r.vld) begin
      bit_cnt_nxt = bit_cnt_nxt + 1'b1;
      if (mark_r.err) begin
        err_cnt_nxt = err_cnt_nxt + 1'b1;
      end
    end
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_IDLE: begin
        if (q_vld) begin
          st_nxt = S_UPD;
        end
      end
      S_UPD:   st_nxt = S_START;
      S_START: st_nxt = S_DIV;
      S_DIV: begin
        if (load) begin
          st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    rd_r <= mem_r[pos_r];
    if (st_r == S_UPD) begin
      mem_r[pos_r] <= mark_r;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      mark_r <= q_mark;
    end
    if (load) begin
      out_r.error_rate       <= div_rate;
      out_r.bits_in_window   <= bit_cnt_r;
      out_r.errors_in_window <= err_cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= S_IDLE;
      pos_r     <= '0;
      wrap_r    <= 1'b0;
      bit_cnt_r <= swber_pkg::CNT_W'(swber_pkg::WINDOW);
      err_cnt_r <= '0;
      out_vld_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (st_r == S_UPD) begin
        bit_cnt_r <= bit_cnt_nxt;
        err_cnt_r <= err_cnt_nxt;
        if (pos_r == swber_pkg::POS_W'(swber_pkg::WINDOW - 1)) begin
          pos_r  <= '0;
          wrap_r <= 1'b1;
        end else begin
          pos_r <= pos_r + 1'b1;
        end
      end
      if (load) begin
        out_vld_r <= 1'b1;
      end else if (out_pop) begin
        out_vld_r <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_err_le_bits: assert property (@(posedge clk) disable iff (!rst_n)
    err_cnt_r <= bit_cnt_r)
    else $error("error count exceeds bit count");

  a_bits_le_window: assert property (@(posedge clk) disable iff (!rst_n)
    bit_cnt_r <= swber_pkg::CNT_W'(swber_pkg::WINDOW))
    else $error("bit count exceeds window");

  a_pop_then_update: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (st_r == S_UPD) && (pos_r == $past(pos_r)))
    else $error("queue pop not followed by window update");

  a_load_needs_div: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_vld_r && $past(!div_done)) |-> !load || div_done)
    else $error("result loaded without divider result");
`endif

endmodule

// ===== rtl/sliding_window_bit_error_rate_top.sv =====
// Sliding window bit error rate meter, top level.
// Each accepted word passes the input queue, a window update, the 16-step serial divider and
// the result register; the back end takes no new word until its result is loaded.
// Input queue of 2 words keeps accepting, until full, while the back end works or a result waits.
// Reset: synchronous, active low; window starts full of valid error-free marks with no
// clearing pass (entries not yet written on the first lap read as that value).
module sliding_window_bit_error_rate_top (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  output logic                  in_full,
  input  swber_pkg::in_item_t   in_item,
  output logic                  out_empty,
  input  logic                  out_pop,
  output swber_pkg::out_item_t  out_item
);

  logic             q_vld;
  logic             q_pop;
  swber_pkg::mark_t q_mark;

  swber_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_full (in_full),
    .in_item (in_item),
    .q_vld   (q_vld),
    .q_mark  (q_mark),
    .q_pop   (q_pop)
  );

  swber_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_vld     (q_vld),
    .q_mark    (q_mark),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

endmodule
